@@ rtl/core/srbs_pkg.sv @@
// Shared types and constants for the sorted record table search unit.
`timescale 1ns / 1ps

package srbs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int ATTR_W      = 16;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_FOUND = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP
    } state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [ATTR_W-1:0]       age;
        logic [ATTR_W-1:0]       height;
        logic [ATTR_W-1:0]       weight;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // controller to datapath
    typedef struct packed {
        logic    clear;
        logic    append;
        logic    init;
        logic    rd_en;
        logic    step;
        logic    emit;
        status_t emit_status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic key_eq;
    } dp_stat_t;

endpackage

@@ rtl/core/srbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module srbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/srbs_dp.sv @@
// Datapath: record memory, fill count, search window and result registers.
`timescale 1ns / 1ps

module srbs_dp
    import srbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic signed [KEY_W-1:0]  key_in,
    input  logic [ATTR_W-1:0]        age_in,
    input  logic [ATTR_W-1:0]        height_in,
    input  logic [ATTR_W-1:0]        weight_in,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [KEY_W-1:0]  key_out,
    output logic [ATTR_W-1:0]        age_out,
    output logic [ATTR_W-1:0]        height_out,
    output logic [ATTR_W-1:0]        weight_out
);

    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        lim_reg, lim_next;   // exclusive upper bound
    logic signed [KEY_W-1:0] want_reg;
    logic [CNT_W-1:0]        mid;
    logic                    done_reg;
    status_t                 status_reg;
    rec_t                    out_reg, out_next;
    rec_t                    wr_rec;
    rec_t                    rd_rec;
    logic                    key_gt;

    assign mid    = lo_reg + ((lim_reg - lo_reg - CNT_W'(1)) >> 1);
    assign key_gt = rd_rec.key > want_reg;

    assign stat.full   = (fill_reg == CNT_W'(TABLE_DEPTH));
    assign stat.empty  = (lo_reg >= lim_reg);
    assign stat.key_eq = (rd_rec.key == want_reg);

    assign wr_rec = '{key: key_in, age: age_in, height: height_in, weight: weight_in};

    srbs_ram #(
        .WIDTH(REC_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (cmd.append),
        .waddr(fill_reg[IDX_W-1:0]),
        .wdata(wr_rec),
        .re   (cmd.rd_en),
        .raddr(mid[IDX_W-1:0]),
        .rdata(rd_rec)
    );

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.clear)
        begin
            fill_next = '0;
        end
        else if (cmd.append)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        lo_next  = lo_reg;
        lim_next = lim_reg;
        if (cmd.init)
        begin
            lo_next  = '0;
            lim_next = fill_reg;
        end
        else if (cmd.step)
        begin
            if (key_gt)
            begin
                lim_next = mid;
            end
            else
            begin
                lo_next = mid + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        out_next = '0;
        if (cmd.emit_status == ST_FOUND)
        begin
            out_next = rd_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            lo_reg   <= '0;
            lim_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            lo_reg   <= lo_next;
            lim_reg  <= lim_next;
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            want_reg <= key_in;
        end
        if (cmd.emit)
        begin
            status_reg <= cmd.emit_status;
            out_reg    <= out_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign key_out    = out_reg.key;
    assign age_out    = out_reg.age;
    assign height_out = out_reg.height;
    assign weight_out = out_reg.weight;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= lim_reg && lim_reg <= CNT_W'(TABLE_DEPTH))
        else $error("search window out of range");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != ST_FOUND |->
            out_reg.key == '0 && out_reg.age == '0 &&
            out_reg.height == '0 && out_reg.weight == '0)
        else $error("nonzero fields without a match");

endmodule

@@ rtl/core/srbs_ctrl.sv @@
// Controller: sequences table updates and binary search probes.
`timescale 1ns / 1ps

module srbs_ctrl
    import srbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  op_t      op,
    input  dp_stat_t stat,
    output logic     busy,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op == OP_LOOKUP)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = stat.empty ? S_IDLE : S_CMP;
            end
            S_CMP:
            begin
                state_next = stat.key_eq ? S_IDLE : S_READ;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '{clear: 1'b0, append: 1'b0, init: 1'b0, rd_en: 1'b0,
                step: 1'b0, emit: 1'b0, emit_status: ST_DONE};
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                            cmd.emit  = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            cmd.emit = 1'b1;
                            if (stat.full)
                            begin
                                cmd.emit_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            cmd.init = 1'b1;
                        end
                        OP_NONE:
                        begin
                            cmd.emit = 1'b1;
                        end
                        default:
                        begin
                            cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (stat.empty)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_MISS;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_CMP:
            begin
                if (stat.key_eq)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_FOUND;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> $past(state_reg) == S_READ)
        else $error("compare without a preceding probe");

    a_no_full_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !stat.full)
        else $error("write into a full table");

    a_one_effect: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.append, cmd.init, cmd.rd_en, cmd.step}))
        else $error("conflicting datapath commands");

endmodule

@@ rtl/core/sorted_record_table_binary_search_unit.sv @@
// Sorted record table with binary search lookup: top level.
`timescale 1ns / 1ps

// An item transfers on a clock edge with start high and busy low. For a
// lookup busy then holds until the result is produced; clear, append and the
// unused operation code leave busy low and raise done for one cycle in the
// cycle after the transfer. A lookup runs the binary search over the filled
// entries of a record memory with separate write and read ports and
// registered read: each probe passes through a read state and a compare
// state, and a search takes at most floor(log2(entries))+1 probes. done is a
// one-cycle strobe that the receiver cannot hold off, so results must be
// captured when it is high. Appends must arrive in ascending key order for
// lookups to find every key.

module sorted_record_table_binary_search_unit
    import srbs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              operation,
    input  logic signed [KEY_W-1:0] key_in,
    input  logic [ATTR_W-1:0]       age_in,
    input  logic [ATTR_W-1:0]       height_in,
    input  logic [ATTR_W-1:0]       weight_in,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [KEY_W-1:0] key_out,
    output logic [ATTR_W-1:0]       age_out,
    output logic [ATTR_W-1:0]       height_out,
    output logic [ATTR_W-1:0]       weight_out
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    srbs_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .op   (op_t'(operation)),
        .stat (stat),
        .busy (busy),
        .cmd  (cmd)
    );

    srbs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .key_in    (key_in),
        .age_in    (age_in),
        .height_in (height_in),
        .weight_in (weight_in),
        .done      (done),
        .status    (status),
        .key_out   (key_out),
        .age_out   (age_out),
        .height_out(height_out),
        .weight_out(weight_out)
    );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the sorted record table binary search unit.
`timescale 1ns / 1ps

module tb
    import srbs_pkg::*;
;

    localparam int N_CMDS     = 1200;
    localparam int QUIET_TAIL = 150;

    typedef struct {
        op_t  op;
        rec_t rec;
    } cmd_t;

    typedef struct {
        status_t status;
        rec_t    rec;
    } reply_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              operation = 2'd0;
    logic signed [KEY_W-1:0] key_in = '0;
    logic [ATTR_W-1:0]       age_in = '0;
    logic [ATTR_W-1:0]       height_in = '0;
    logic [ATTR_W-1:0]       weight_in = '0;
    logic                    done;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] key_out;
    logic [ATTR_W-1:0]       age_out;
    logic [ATTR_W-1:0]       height_out;
    logic [ATTR_W-1:0]       weight_out;

    cmd_t   table_cmds[$];
    reply_t predicted_replies[$];
    cmd_t   on_port;
    int     idle_left = 0;
    int     mismatches = 0;

    rec_t             table_mem [TABLE_DEPTH];
    logic [CNT_W-1:0] table_fill = '0;

    sorted_record_table_binary_search_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .key_in     (key_in),
        .age_in     (age_in),
        .height_in  (height_in),
        .weight_in  (weight_in),
        .done       (done),
        .status     (status),
        .key_out    (key_out),
        .age_out    (age_out),
        .height_out (height_out),
        .weight_out (weight_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Table model: clear, append, or binary search over the filled entries.
    function automatic reply_t run_table_cmd(input cmd_t c);
        reply_t r;
        int     lo;
        int     hi;
        int     mid;
        r.status = ST_DONE;
        r.rec    = '0;
        case (c.op)
            OP_CLEAR:
                table_fill = '0;
            OP_APPEND:
                if (table_fill == TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    table_mem[table_fill[IDX_W-1:0]] = c.rec;
                    table_fill++;
                end
            OP_LOOKUP:
            begin
                r.status = ST_MISS;
                lo = 0;
                hi = int'(table_fill) - 1;
                while (lo <= hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if ($signed(table_mem[mid].key) == $signed(c.rec.key))
                    begin
                        r.status = ST_FOUND;
                        r.rec    = table_mem[mid];
                        lo       = hi + 1;
                    end
                    else if ($signed(table_mem[mid].key) > $signed(c.rec.key))
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void add_cmd(input op_t op, input int key,
                                    input logic [ATTR_W-1:0] age,
                                    input logic [ATTR_W-1:0] height,
                                    input logic [ATTR_W-1:0] weight);
        cmd_t c;
        c.op         = op;
        c.rec.key    = key;
        c.rec.age    = age;
        c.rec.height = height;
        c.rec.weight = weight;
        table_cmds.push_back(c);
    endfunction

    function automatic logic [ATTR_W-1:0] rand_attr();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return ATTR_W'($urandom());
        endcase
    endfunction

    // narrow keys cluster around zero so duplicates show up
    function automatic int pick_key(input bit narrow);
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            default: return narrow ? int'($urandom_range(0, 20)) - 10 : int'($urandom());
        endcase
    endfunction

    // driver: one transfer per start/!busy edge, random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            operation <= OP_CLEAR;
            key_in    <= '0;
            age_in    <= '0;
            height_in <= '0;
            weight_in <= '0;
            idle_left = 0;
        end
        else if (!start || !busy)
        begin
            if (start)
                predicted_replies.push_back(run_table_cmd(on_port));
            if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (table_cmds.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
            begin
                idle_left = $urandom_range(0, 9);
                start <= 1'b0;
            end
            else if (table_cmds.size() != 0)
            begin
                on_port = table_cmds.pop_front();
                start     <= 1'b1;
                operation <= on_port.op;
                key_in    <= on_port.rec.key;
                age_in    <= on_port.rec.age;
                height_in <= on_port.rec.height;
                weight_in <= on_port.rec.weight;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: done is a single-cycle strobe, compare against oldest prediction
    always @(posedge clk)
    begin : check_reply
        reply_t want;
        if (rst_n && done)
        begin
            if (predicted_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %0d %0d %0d %0d %0d",
                             status, key_out, age_out, height_out, weight_out);
            end
            else
            begin
                want = predicted_replies.pop_front();
                if (status !== want.status || key_out !== want.rec.key ||
                    age_out !== want.rec.age || height_out !== want.rec.height ||
                    weight_out !== want.rec.weight)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                 want.status, want.rec.key, want.rec.age, want.rec.height,
                                 want.rec.weight, status, key_out, age_out, height_out,
                                 weight_out);
                end
            end
        end
    end

    initial
    begin
        int seq_keys[$];
        int fresh[$];
        int dir_keys[16];
        int n;
        int mode;
        int m;
        int pick;
        int k;

        dir_keys = '{32'sh8000_0000, -100000, -1000, -10, -1, 0, 1, 10, 100, 1000,
                     65535, 65536, 1000000, 32'sh4000_0000, 32'sh7fff_fffe, 32'sh7fff_ffff};

        // directed: empty lookup, unused opcode, fill to the brim, reject, hits and misses
        add_cmd(OP_LOOKUP, 0, '0, '0, '0);
        add_cmd(OP_NONE, -1, '1, '1, '1);
        for (int i = 0; i < 16; i++)
        begin
            if (i == 0)
                add_cmd(OP_APPEND, dir_keys[i], '0, '0, '0);
            else if (i == 15)
                add_cmd(OP_APPEND, dir_keys[i], '1, '1, '1);
            else
                add_cmd(OP_APPEND, dir_keys[i], ATTR_W'(i), ATTR_W'(i * 300), ATTR_W'(i * 7));
        end
        add_cmd(OP_APPEND, 5, 16'h1234, 16'h5678, 16'h9abc);
        add_cmd(OP_LOOKUP, 32'sh8000_0000, '0, '0, '0);
        add_cmd(OP_LOOKUP, 32'sh7fff_ffff, '1, '1, '1);
        add_cmd(OP_LOOKUP, 10, '0, '0, '0);
        add_cmd(OP_LOOKUP, 5, '0, '0, '0);
        add_cmd(OP_LOOKUP, 32'sh8000_0001, '0, '0, '0);
        add_cmd(OP_CLEAR, 32'sh7fff_ffff, '1, '1, '1);

        // random: mostly clear + sorted appends + lookups, some unsorted or overfilled
        while (table_cmds.size() < N_CMDS)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                add_cmd(OP_CLEAR, pick_key(0), rand_attr(), rand_attr(), rand_attr());
                seq_keys.delete();
            end
            n    = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 12);
            mode = $urandom_range(0, 9);
            fresh.delete();
            for (int i = 0; i < n; i++)
                fresh.push_back(pick_key(mode == 7 || mode == 9));
            if (mode < 8)
                fresh.sort();
            foreach (fresh[i])
            begin
                add_cmd(OP_APPEND, fresh[i], rand_attr(), rand_attr(), rand_attr());
                seq_keys.push_back(fresh[i]);
            end
            m = $urandom_range(1, 12);
            for (int i = 0; i < m; i++)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    add_cmd(OP_NONE, pick_key(0), rand_attr(), rand_attr(), rand_attr());
                else
                begin
                    if (seq_keys.size() != 0 && pick < 13)
                        k = seq_keys[$urandom_range(0, seq_keys.size() - 1)];
                    else if (seq_keys.size() != 0 && pick < 16)
                        k = seq_keys[$urandom_range(0, seq_keys.size() - 1)] +
                            ((pick == 13) ? 1 : -1);
                    else
                        k = pick_key(mode == 7 || mode == 9);
                    add_cmd(OP_LOOKUP, k, rand_attr(), rand_attr(), rand_attr());
                end
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (table_cmds.size() != 0 || start)
            @(posedge clk);
        while (predicted_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && predicted_replies.size() == 0)
            $display("[sorted_record_table_binary_search_unit] OK");
        else
            $display("[sorted_record_table_binary_search_unit] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[sorted_record_table_binary_search_unit] ERROR");
        $finish;
    end

endmodule

@@ sorted_record_table_binary_search_unit.f @@
rtl/core/srbs_pkg.sv
rtl/core/srbs_ram.sv
rtl/core/srbs_dp.sv
rtl/core/srbs_ctrl.sv
rtl/core/sorted_record_table_binary_search_unit.sv
verif/tb.sv
